>>> rtl/core/tsrs_pkg.sv
// types, codes and arithmetic helpers shared by the temperature read sequencer
`default_nettype none
package tsrs_pkg;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_CONV_RESET = 4'd1,
        ST_CONV_SKIP  = 4'd2,
        ST_CONV_CMD   = 4'd3,
        ST_WAIT       = 4'd4,
        ST_READ_RESET = 4'd5,
        ST_READ_SKIP  = 4'd6,
        ST_READ_CMD   = 4'd7,
        ST_RECEIVE    = 4'd8,
        ST_POST_RESET = 4'd9,
        ST_COMPLETE   = 4'd10,
        ST_ERROR      = 4'd11
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_RESET = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_READ  = 3'd3,
        ACT_POLL  = 3'd4
    } action_t;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    localparam logic [7:0] CMD_NONE     = 8'h00;
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    typedef struct packed {
        logic       func;
        logic       reset_presence_ok;
        logic       conversion_done;
        logic [7:0] scratch_low;
        logic [7:0] scratch_high;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         bus_action;
        logic [7:0]         command_byte;
        logic               start_accepted;
        logic               busy_flag;
        logic               ready_flag;
        logic               complete_flag;
        logic               error_flag;
        logic [3:0]         state_code;
        logic signed [15:0] temperature_deci;
    } out_item_t;

    // raw * 10 / 16, truncated toward zero
    function automatic logic signed [15:0] raw_to_deci(input logic [7:0] lo,
                                                       input logic [7:0] hi);
        logic signed [19:0] raw_ext;
        logic signed [19:0] prod;
        logic signed [19:0] biased;
        logic signed [19:0] quot;
        raw_ext = 20'(signed'({hi, lo}));
        prod    = (raw_ext <<< 3) + (raw_ext <<< 1);
        biased  = prod[19] ? (prod + 20'sd15) : prod;
        quot    = biased >>> 4;
        return quot[15:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tsrs_in_stage.sv
// input register stage of the temperature read sequencer
`default_nettype none
module tsrs_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tsrs_pkg::in_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output tsrs_pkg::in_item_t     item
);

    logic               valid_reg;
    logic               valid_next;
    tsrs_pkg::in_item_t item_reg;

    // slot frees up whenever its item moves on to the core
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

>>> rtl/core/tsrs_seq_core.sv
// sequence state machine and temperature conversion
`default_nettype none
module tsrs_seq_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire tsrs_pkg::in_item_t item,
    output tsrs_pkg::out_item_t     result
);

    tsrs_pkg::state_t   step_reg,  step_next;
    logic signed [15:0] temp_reg,  temp_next;
    logic               busy_reg,  busy_next;
    logic               ready_reg, ready_next;
    logic               error_reg, error_next;
    tsrs_pkg::action_t  action;
    logic [7:0]         cmd;
    logic               accepted;
    logic signed [15:0] deci;

    assign deci = tsrs_pkg::raw_to_deci(item.scratch_low, item.scratch_high);

    // next state
    always_comb begin
        step_next  = step_reg;
        temp_next  = temp_reg;
        busy_next  = busy_reg;
        ready_next = ready_reg;
        error_next = error_reg;
        if (item.func == tsrs_pkg::FUNC_START) begin
            if (!busy_reg) begin
                step_next  = tsrs_pkg::ST_CONV_RESET;
                temp_next  = '0;
                busy_next  = 1'b1;
                ready_next = 1'b0;
                error_next = 1'b0;
            end
        end else begin
            unique case (step_reg)
                tsrs_pkg::ST_IDLE, tsrs_pkg::ST_COMPLETE, tsrs_pkg::ST_ERROR: begin
                end
                tsrs_pkg::ST_CONV_RESET, tsrs_pkg::ST_READ_RESET: begin
                    if (item.reset_presence_ok) begin
                        step_next = (step_reg == tsrs_pkg::ST_CONV_RESET) ?
                                    tsrs_pkg::ST_CONV_SKIP : tsrs_pkg::ST_READ_SKIP;
                    end else begin
                        step_next  = tsrs_pkg::ST_ERROR;
                        busy_next  = 1'b0;
                        ready_next = 1'b0;
                        error_next = 1'b1;
                    end
                end
                tsrs_pkg::ST_CONV_SKIP: step_next = tsrs_pkg::ST_CONV_CMD;
                tsrs_pkg::ST_CONV_CMD:  step_next = tsrs_pkg::ST_WAIT;
                tsrs_pkg::ST_WAIT: begin
                    if (item.conversion_done) begin
                        step_next = tsrs_pkg::ST_READ_RESET;
                    end
                end
                tsrs_pkg::ST_READ_SKIP: step_next = tsrs_pkg::ST_READ_CMD;
                tsrs_pkg::ST_READ_CMD:  step_next = tsrs_pkg::ST_RECEIVE;
                tsrs_pkg::ST_RECEIVE: begin
                    temp_next = deci;
                    step_next = tsrs_pkg::ST_POST_RESET;
                end
                tsrs_pkg::ST_POST_RESET: begin
                    if (item.reset_presence_ok) begin
                        step_next  = tsrs_pkg::ST_COMPLETE;
                        busy_next  = 1'b0;
                        ready_next = 1'b1;
                        error_next = 1'b0;
                    end else begin
                        step_next  = tsrs_pkg::ST_ERROR;
                        busy_next  = 1'b0;
                        ready_next = 1'b0;
                        error_next = 1'b1;
                    end
                end
                default: begin
                    // unreachable step codes fall into error
                    step_next  = tsrs_pkg::ST_ERROR;
                    busy_next  = 1'b0;
                    ready_next = 1'b0;
                    error_next = 1'b1;
                end
            endcase
        end
    end

    // bus request for this item
    always_comb begin
        action   = tsrs_pkg::ACT_NONE;
        cmd      = tsrs_pkg::CMD_NONE;
        accepted = 1'b0;
        if (item.func == tsrs_pkg::FUNC_START) begin
            accepted = !busy_reg;
        end else begin
            unique case (step_reg)
                tsrs_pkg::ST_CONV_RESET, tsrs_pkg::ST_READ_RESET,
                tsrs_pkg::ST_POST_RESET: action = tsrs_pkg::ACT_RESET;
                tsrs_pkg::ST_CONV_SKIP, tsrs_pkg::ST_READ_SKIP: begin
                    action = tsrs_pkg::ACT_WRITE;
                    cmd    = tsrs_pkg::CMD_SKIP_ROM;
                end
                tsrs_pkg::ST_CONV_CMD: begin
                    action = tsrs_pkg::ACT_WRITE;
                    cmd    = tsrs_pkg::CMD_CONVERT;
                end
                tsrs_pkg::ST_READ_CMD: begin
                    action = tsrs_pkg::ACT_WRITE;
                    cmd    = tsrs_pkg::CMD_READ_PAD;
                end
                tsrs_pkg::ST_WAIT:    action = tsrs_pkg::ACT_POLL;
                tsrs_pkg::ST_RECEIVE: action = tsrs_pkg::ACT_READ;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= tsrs_pkg::ST_IDLE;
            temp_reg  <= '0;
            busy_reg  <= 1'b0;
            ready_reg <= 1'b0;
            error_reg <= 1'b0;
        end else if (fire) begin
            step_reg  <= step_next;
            temp_reg  <= temp_next;
            busy_reg  <= busy_next;
            ready_reg <= ready_next;
            error_reg <= error_next;
        end
    end

    always_comb begin
        result.bus_action       = action;
        result.command_byte     = cmd;
        result.start_accepted   = accepted;
        result.busy_flag        = busy_next;
        result.ready_flag       = ready_next;
        result.complete_flag    = (step_next == tsrs_pkg::ST_COMPLETE) && ready_next;
        result.error_flag       = error_next;
        result.state_code       = step_next;
        result.temperature_deci = ready_next ? temp_next : 16'sd0;
    end

endmodule
`default_nettype wire

>>> rtl/core/tsrs_out_stage.sv
// result register stage of the temperature read sequencer
`default_nettype none
module tsrs_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire tsrs_pkg::out_item_t result,
    output logic                     advance,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tsrs_pkg::out_item_t      m_item
);

    logic                valid_reg;
    logic                valid_next;
    tsrs_pkg::out_item_t item_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule
`default_nettype wire

>>> rtl/core/temperature_sensor_read_sequencer.sv
// top level of the one-wire temperature convert-and-read sequencer
//
// input channel s_valid/s_ready/s_item carries start requests (func 0) and
// ticks (func 1) together with what the last bus operation saw
// result channel m_valid/m_ready/m_item returns one item per input item:
// the bus operation to run next, its command byte, the status flags, the
// step code and the last temperature in tenths of a degree
// an accepted item is registered into the input stage, and its result is
// loaded into the result register, raising m_valid, when that has room
// throughput: one item per cycle while the receiver does not stall, set by
// the single pass through the step logic between the input register and
// the result register
// a stalled receiver holds the result register; the input stage still
// takes one more item, and s_ready drops once both registers are full
// reset (aresetn low, synchronous) empties both stages and puts the
// sequencer in idle with busy, ready and error cleared and temperature zero
`default_nettype none
module temperature_sensor_read_sequencer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tsrs_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tsrs_pkg::out_item_t      m_item
);

    logic                advance;    // result register can take a new item
    logic                item_valid; // input stage holds an item
    logic                fire;       // item moves through the step logic
    tsrs_pkg::in_item_t  item;
    tsrs_pkg::out_item_t result;

    assign fire = item_valid && advance;

    tsrs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // state only moves when the item's result is stored
    tsrs_seq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    tsrs_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (item_valid),
        .result  (result),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef SYNTHESIS
    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result register");

    // busy and error exclude each other
    a_busy_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.busy_flag && m_item.error_flag))
        else $error("busy and error both set");

    // complete implies ready
    a_complete_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.complete_flag |-> m_item.ready_flag)
        else $error("complete without ready");

    // temperature only shown when ready
    a_temp_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.ready_flag |-> m_item.temperature_deci == 16'sd0)
        else $error("temperature shown while not ready");
`endif

endmodule
`default_nettype wire
